/* hw/rtl/ghe_pkg.sv */
`timescale 1ns / 1ps

package ghe_pkg;

  localparam int MAX_PIXELS  = 65536;
  localparam int GRAY_LEVELS = 256;
  localparam int PIX_AW      = $clog2(MAX_PIXELS);
  localparam int CNT_W       = PIX_AW + 1;
  localparam int GRAY_W      = 8;
  localparam int LVL_W       = $clog2(GRAY_LEVELS);
  localparam int MAP_MAX     = 255;
  localparam int REM_W       = CNT_W + GRAY_W;
  localparam int PIX_W       = 3 * GRAY_W;

  // luma weights in thousandths
  localparam int COEF_R      = 299;
  localparam int COEF_G      = 587;
  localparam int COEF_B      = 114;
  localparam int SUM_W       = 18;

  // floor(s / 1000) = (s * RECIP) >> RECIP_SH for s up to 255000
  localparam int RECIP       = 268436;
  localparam int RECIP_W     = 19;
  localparam int RECIP_SH    = 28;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_LOADING = 2'd1,
    PH_READY   = 2'd2
  } phase_t;

  typedef struct packed {
    logic load_sum;
    logic frame_start;
    logic div;
    logic store;
    logic count;
    logic bin_sel_v;
    logic build_init;
    logic build_acc;
    logic build_step;
    logic rp_clear;
    logic out_load;
    logic out_err;
  } ghe_cmd_t;

  typedef struct packed {
    logic rp_ok;
    logic eof;
    logic sub_more;
    logic v_last;
    logic out_free;
  } ghe_stat_t;

endpackage

/* hw/rtl/ghe_dp.sv */
`timescale 1ns / 1ps

module ghe_dp import ghe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ghe_cmd_t          cmd,
  output ghe_stat_t         stat,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [GRAY_W-1:0] m_tdata,
  output logic              m_tlast,
  output logic              m_tuser
);

  logic [SUM_W-1:0]       wsum;
  logic [SUM_W-1:0]       wsum_next;
  logic [PROD_W-1:0]      prod;
  logic [GRAY_W-1:0]      gray_r;
  logic [CNT_W-1:0]       total;
  logic [CNT_W-1:0]       rp;
  logic                   full;

  logic [CNT_W-1:0]       hist_mem [GRAY_LEVELS];
  logic [GRAY_LEVELS-1:0] bin_valid;
  logic [LVL_W-1:0]       bin_addr;
  logic [CNT_W-1:0]       hist_q;
  logic                   hist_vq;
  logic [CNT_W-1:0]       hist_cnt;

  logic [LVL_W-1:0]       v;
  logic [REM_W-1:0]       rem;
  logic [GRAY_W-1:0]      q;

  logic [GRAY_W-1:0]      frame_mem [MAX_PIXELS];
  logic [GRAY_W-1:0]      fs_q;
  logic [GRAY_W-1:0]      map_mem [GRAY_LEVELS];
  logic [GRAY_W-1:0]      map_q;

  logic                   out_valid;
  logic [GRAY_W-1:0]      out_gray;
  logic                   out_eof;
  logic                   out_status;

  assign wsum_next = SUM_W'(COEF_R) * SUM_W'(pixel[GRAY_W-1:0])
                   + SUM_W'(COEF_G) * SUM_W'(pixel[2*GRAY_W-1:GRAY_W])
                   + SUM_W'(COEF_B) * SUM_W'(pixel[3*GRAY_W-1:2*GRAY_W]);
  assign prod      = PROD_W'(wsum) * PROD_W'(RECIP);

  assign full      = (total == CNT_W'(MAX_PIXELS));
  assign bin_addr  = cmd.bin_sel_v ? v : LVL_W'(gray_r);
  assign hist_cnt  = hist_vq ? hist_q : '0;

  assign stat.rp_ok    = (rp < total);
  assign stat.eof      = ((rp + CNT_W'(1)) == total);
  assign stat.sub_more = (total != '0) && (rem >= REM_W'(total));
  assign stat.v_last   = (v == LVL_W'(GRAY_LEVELS - 1));
  assign stat.out_free = !out_valid || m_tready;

  // weighted sum, then divide by 1000 through the reciprocal
  always_ff @(posedge clk) begin
    if (cmd.load_sum) begin
      wsum <= wsum_next;
    end
    if (cmd.div) begin
      gray_r <= prod[RECIP_SH +: GRAY_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      rp        <= '0;
      bin_valid <= '0;
    end else begin
      if (cmd.frame_start) begin
        total     <= '0;
        rp        <= '0;
        bin_valid <= '0;
      end else if (cmd.count && !full) begin
        total            <= total + CNT_W'(1);
        bin_valid[gray_r] <= 1'b1;
      end
      if (cmd.rp_clear) begin
        rp <= '0;
      end else if (cmd.out_load && !cmd.out_err) begin
        rp <= rp + CNT_W'(1);
      end
    end
  end

  // histogram store, bins not marked valid read as zero
  always_ff @(posedge clk) begin
    if (cmd.count && !full) begin
      hist_mem[gray_r] <= hist_cnt + CNT_W'(1);
    end
    hist_q  <= hist_mem[bin_addr];
    hist_vq <= bin_valid[bin_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      frame_mem[total[PIX_AW-1:0]] <= gray_r;
    end
    fs_q <= frame_mem[rp[PIX_AW-1:0]];
  end

  // running quotient: rem = cdf * 255 - q * total
  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      v   <= '0;
      rem <= '0;
      q   <= '0;
    end else if (cmd.build_acc) begin
      rem <= rem + REM_W'(hist_cnt) * REM_W'(MAP_MAX);
    end else if (cmd.build_step) begin
      if (stat.sub_more) begin
        rem <= rem - REM_W'(total);
        q   <= q + GRAY_W'(1);
      end else begin
        v <= v + LVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_step && !stat.sub_more) begin
      map_mem[v] <= q;
    end
    map_q <= map_mem[fs_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_gray   <= cmd.out_err ? '0 : map_q;
      out_eof    <= !cmd.out_err && stat.eof;
      out_status <= cmd.out_err;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_gray;
  assign m_tlast  = out_eof;
  assign m_tuser  = out_status;

endmodule

/* hw/rtl/ghe_ctrl.sv */
`timescale 1ns / 1ps

module ghe_ctrl import ghe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  input  logic      s_tuser,
  input  logic      s_tlast,
  output logic      s_tready,
  input  ghe_stat_t stat,
  output ghe_cmd_t  cmd
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_DIV  = 10'b0000000010,
    ST_HRD  = 10'b0000000100,
    ST_HWR  = 10'b0000001000,
    ST_BRD  = 10'b0000010000,
    ST_BACC = 10'b0000100000,
    ST_BSUB = 10'b0001000000,
    ST_RMEM = 10'b0010000000,
    ST_RMAP = 10'b0100000000,
    ST_ROUT = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;
  phase_t phase;
  phase_t phase_next;
  logic   last_r;
  logic   err_r;
  logic   accept;
  logic   read_err;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign read_err = (phase != PH_READY) || !stat.rp_ok;

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == OP_LOAD) begin
            cmd.load_sum = 1'b1;
            // a load outside a frame opens a new one
            if (phase != PH_LOADING) begin
              cmd.frame_start = 1'b1;
            end
            phase_next = PH_LOADING;
            state_next = ST_DIV;
          end else if (read_err) begin
            state_next = ST_ROUT;
          end else begin
            state_next = ST_RMEM;
          end
        end
      end
      ST_DIV: begin
        cmd.div    = 1'b1;
        state_next = ST_HRD;
      end
      ST_HRD: begin
        cmd.store  = 1'b1;
        state_next = ST_HWR;
      end
      ST_HWR: begin
        cmd.count = 1'b1;
        if (last_r) begin
          cmd.build_init = 1'b1;
          state_next     = ST_BRD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BRD: begin
        cmd.bin_sel_v = 1'b1;
        state_next    = ST_BACC;
      end
      ST_BACC: begin
        cmd.build_acc = 1'b1;
        state_next    = ST_BSUB;
      end
      ST_BSUB: begin
        cmd.build_step = 1'b1;
        if (!stat.sub_more) begin
          if (stat.v_last) begin
            cmd.rp_clear = 1'b1;
            phase_next   = PH_READY;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_BRD;
          end
        end
      end
      ST_RMEM: begin
        state_next = ST_RMAP;
      end
      ST_RMAP: begin
        state_next = ST_ROUT;
      end
      ST_ROUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_err  = err_r;
          if (!err_r && stat.eof) begin
            phase_next = PH_IDLE;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_IDLE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= s_tlast;
      err_r  <= read_err;
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten before taken");

  a_load_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == OP_LOAD) |=> (phase == PH_LOADING))
    else $error("load did not leave phase in loading");

  a_build_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BSUB && !stat.sub_more && stat.v_last) |=> (phase == PH_READY))
    else $error("map build finished without ready phase");

  a_readout_done: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && !cmd.out_err && stat.eof) |=> (phase == PH_IDLE))
    else $error("frame read out but phase not idle");

endmodule

/* hw/rtl/gray_histogram_equalizer.sv */
`timescale 1ns / 1ps
// load request, from one accept to the next: sum, reciprocal divide, bin read, bin write
// read request: result registered after frame store read and level map read, once output is free
// error read: result registered without store reads; a waiting result does not block acceptance
// map build after last pixel: per gray level, bin read, accumulate, quotient steps, map store
// reset clears control, pixel count, read pointer and bin valid bits; stores are not swept

module gray_histogram_equalizer import ghe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [PIX_W-1:0]  s_tdata,   // red, green, blue
  input  logic              s_tlast,   // last_pixel
  input  logic              s_tuser,   // opcode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [GRAY_W-1:0] m_tdata,   // gray_out
  output logic              m_tlast,   // end_of_frame
  output logic              m_tuser    // status
);

  ghe_cmd_t  cmd;
  ghe_stat_t stat;

  ghe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ghe_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .pixel    (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

/* dv/tb_gray_histogram_equalizer.sv */
`timescale 1ns / 1ps

module tb_gray_histogram_equalizer;
  import ghe_pkg::*;

  localparam logic ST_OK       = 1'b0;
  localparam logic ST_NO_FRAME = 1'b1;
  localparam int   RANDOM_REQS = 1050;
  localparam int   IDLE_LIMIT  = 5000;
  localparam int   DRAIN_WAIT  = 1100;

  typedef struct packed {
    logic       op;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] gray;
    logic       eof;
    logic       status;
  } gray_res_t;

  // fixed = 1: expected result typed in the row, otherwise taken from the predictor
  typedef struct packed {
    pixel_req_t req;
    logic       fixed;
    gray_res_t  res;
  } dir_row_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0,   1'b0, ST_NO_FRAME}},
    '{'{OP_LOAD, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{8'd0,   1'b0, ST_NO_FRAME}},
    '{'{OP_LOAD, 8'd255, 8'd255, 8'd255, 1'b1}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0,   1'b0, ST_NO_FRAME}},
    '{'{OP_LOAD, 8'd255, 8'd0,   8'd0,   1'b1}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd255, 1'b1, ST_OK}},
    '{'{OP_LOAD, 8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_LOAD, 8'd0,   8'd0,   8'd255, 1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_LOAD, 8'd1,   8'd2,   8'd3,   1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0,   1'b0, ST_NO_FRAME}},
    '{'{OP_LOAD, 8'd128, 8'd128, 8'd128, 1'b1}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_LOAD, 8'd10,  8'd200, 8'd30,  1'b1}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd170, 8'd85,  8'd170, 1'b1}, 1'b1, '{8'd0,   1'b0, ST_NO_FRAME}},
    '{'{OP_LOAD, 8'd170, 8'd85,  8'd170, 1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_LOAD, 8'd85,  8'd170, 8'd85,  1'b1}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '{8'd0,   1'b0, ST_OK}},
    '{'{OP_READ, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0,   1'b0, ST_NO_FRAME}}
  };

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [PIX_W-1:0]  s_tdata = '0;   // red, green, blue
  logic              s_tlast = 1'b0; // last_pixel
  logic              s_tuser = 1'b0; // opcode
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [GRAY_W-1:0] m_tdata;        // gray_out
  logic              m_tlast;        // end_of_frame
  logic              m_tuser;        // status

  gray_histogram_equalizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // predictor state
  logic [7:0]  frame_mem [MAX_PIXELS];
  int unsigned bin_tally [GRAY_LEVELS];
  logic [7:0]  level_lut [GRAY_LEVELS];
  int unsigned px_count;
  int unsigned rd_idx;
  phase_t      frame_phase = PH_IDLE;

  gray_res_t expected_pixels [$];
  gray_res_t want;
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        reqs_sent = 0;
  int        burst_left = 0;
  int        gap_len;
  int        rx_span = 0;
  int        rx_mode = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    int unsigned weighted;
    weighted = 299 * r + 587 * g + 114 * b;
    return 8'(weighted / 1000);
  endfunction

  function automatic bit predict_pixel(input pixel_req_t rq, output gray_res_t res);
    logic [7:0]      g;
    longint unsigned cum;
    res = '{gray: 8'd0, eof: 1'b0, status: ST_NO_FRAME};
    if (rq.op == OP_LOAD) begin
      g = luma(rq.red, rq.green, rq.blue);
      if (frame_phase != PH_LOADING) begin
        foreach (bin_tally[v]) bin_tally[v] = 0;
        px_count    = 0;
        rd_idx      = 0;
        frame_phase = PH_LOADING;
      end
      // beyond capacity the pixel is dropped, but its last mark still counts
      if (px_count < MAX_PIXELS) begin
        frame_mem[px_count] = g;
        bin_tally[g]++;
        px_count++;
      end
      if (rq.last) begin
        cum = 0;
        for (int v = 0; v < GRAY_LEVELS; v++) begin
          cum += bin_tally[v];
          level_lut[v] = (px_count == 0) ? 8'd0 : 8'((cum * 255) / px_count);
        end
        rd_idx      = 0;
        frame_phase = PH_READY;
      end
      return 1'b0;
    end
    if (frame_phase != PH_READY || rd_idx >= px_count) return 1'b1;
    res.gray   = level_lut[frame_mem[rd_idx]];
    res.eof    = (rd_idx + 1 == px_count);
    res.status = ST_OK;
    rd_idx++;
    if (res.eof) frame_phase = PH_IDLE;
    return 1'b1;
  endfunction

  task automatic send_request(input pixel_req_t rq, input bit fixed, input gray_res_t fixed_res);
    gray_res_t predicted;
    bit        has_res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap_len != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= rq.op;
    s_tdata  <= {rq.blue, rq.green, rq.red};
    s_tlast  <= rq.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    has_res = predict_pixel(rq, predicted);
    if (has_res) expected_pixels.push_back(fixed ? fixed_res : predicted);
    reqs_sent++;
  endtask

  function automatic logic [7:0] edge_chan();
    case ($urandom_range(0, 2))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_req_t random_req();
    pixel_req_t rq;
    rq.op    = 1'($urandom_range(0, 1));
    rq.red   = 8'($urandom);
    rq.green = 8'($urandom);
    rq.blue  = 8'($urandom);
    rq.last  = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  // receiver: ready pattern switches to a randomly chosen mode whenever its random span runs out
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode <= $urandom_range(0, 4);
      rx_span <= $urandom_range(20, 300);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= ~m_tready;
      3:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: gray_out=%0d end_of_frame=%0b status=%0b",
                 m_tdata, m_tlast, m_tuser);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (m_tdata !== want.gray) begin
            $error("gray_out: expected %0d, got %0d", want.gray, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.eof) begin
            $error("end_of_frame: expected %0b, got %0b", want.eof, m_tlast);
            mismatches++;
          end
          if (m_tuser !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, m_tuser);
            mismatches++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    pixel_req_t rq;
    gray_res_t  no_res;
    logic [23:0] palette [4];
    int n, k, mix, stop_at;
    no_res = '{gray: 8'd0, eof: 1'b0, status: ST_OK};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) send_request(DIRECTED[i].req, DIRECTED[i].fixed,
                                                    DIRECTED[i].res);

    stop_at = reqs_sent + RANDOM_REQS;
    while (reqs_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: stray loads, stray last marks, reads at any phase
        repeat ($urandom_range(1, 4)) send_request(random_req(), 1'b0, no_res);
      end else begin
        n   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 12);
        mix = $urandom_range(0, 3);
        foreach (palette[j]) palette[j] = 24'($urandom);
        for (int i = 0; i < n; i++) begin
          rq = random_req();
          case (mix)
            1: {rq.blue, rq.green, rq.red} = palette[$urandom_range(0, 3)];
            2: begin
              rq.red   = edge_chan();
              rq.green = edge_chan();
              rq.blue  = edge_chan();
            end
            3: begin
              rq.green = rq.red;
              rq.blue  = rq.red;
            end
            default: ;
          endcase
          rq.op   = OP_LOAD;
          rq.last = (i == n - 1);
          if ($urandom_range(0, 9) == 0) begin
            // read while the frame is still loading
            rq.op = OP_READ;
            send_request(rq, 1'b0, no_res);
            rq.op = OP_LOAD;
          end
          send_request(rq, 1'b0, no_res);
        end
        // mostly a full read-out, sometimes one past the end, sometimes abandoned
        k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1)
                                        : n + int'($urandom_range(0, 2) == 0);
        repeat (k) begin
          rq    = random_req();
          rq.op = OP_READ;
          send_request(rq, 1'b0, no_res);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
